[rtl/servo_move_queue_sequencer_core_macros.svh]
`ifndef SERVO_MOVE_QUEUE_SEQUENCER_CORE_MACROS_SVH
`define SERVO_MOVE_QUEUE_SEQUENCER_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define SMQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante
`define SMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/smq_pkg.sv]
package smq_pkg;

	// Default configuration
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int CHANNELS_DEF    = 4;

	// Field widths
	localparam int OP_W     = 4;
	localparam int IDX_W    = 2;
	localparam int POS_W    = 10;
	localparam int MEAS_W   = 12;
	localparam int TOL_W    = 10;
	localparam int CMP_W    = 11;
	localparam int STATUS_W = 8;
	localparam int VEC_W    = 4;
	localparam int SLOT_W   = 4;
	localparam int COUNT_W  = 4;

	// Constants
	localparam logic [TOL_W-1:0] TOL_RESET    = 10'd10;
	localparam int               PULSE_OFFSET = 250;
	localparam int               POS_MAX      = 1000;
	localparam int               COUNT_MAX    = 15;

	typedef enum logic [OP_W-1:0] {
		OP_ARM         = 4'd0,
		OP_DISARM      = 4'd1,
		OP_DISARM_ALL  = 4'd2,
		OP_SET_POS     = 4'd3,
		OP_POLL        = 4'd4,
		OP_CHECK       = 4'd5,
		OP_COMPLETE    = 4'd6,
		OP_CLEAR       = 4'd7,
		OP_CLEAR_CHAN  = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		ST_DISARMED = 2'd0,
		ST_ARMED    = 2'd1,
		ST_MOVING   = 2'd2,
		ST_ERROR    = 2'd3
	} ch_state_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_ROT,
		SQ_SORT,
		SQ_FIN
	} seq_state_t;

	// One ring slot as it travels along the chain
	typedef struct packed {
		logic             keep;
		logic [IDX_W-1:0] chan;
		logic [POS_W-1:0] pos;
	} slot_t;

	// Sequencer to cells
	typedef struct packed {
		logic mark;
		logic rot;
		logic sort;
		logic phase;
	} cell_ctl_t;

	// Sequencer to top level
	typedef struct packed {
		logic busy;
		logic fin;
	} seq_stat_t;

	typedef struct packed {
		logic                done_res;
		logic [STATUS_W-1:0] status_word;
		logic [IDX_W-1:0]    event_channel;
		logic                compare_valid;
		logic [CMP_W-1:0]    compare_value;
		logic [VEC_W-1:0]    pwm_enables;
		logic [VEC_W-1:0]    reset_lines;
		logic                reset_pulse;
		logic                move_failed;
		logic [SLOT_W-1:0]   failed_slot;
		logic [COUNT_W-1:0]  queue_count;
	} res_t;

endpackage

[rtl/smq_cell.sv]
module smq_cell import smq_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	parameter int PTR_W = $clog2(QUEUE_DEPTH_DEF),
	parameter int IDX   = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic             push,
	input  logic [PTR_W-1:0] head,
	input  logic [PTR_W-1:0] tail,
	input  logic [IDX_W-1:0] rm_chan,
	input  logic [IDX_W-1:0] wr_chan,
	input  logic [POS_W-1:0] wr_pos,
	input  slot_t            left,
	input  slot_t            right,
	output slot_t            slot
);

	localparam logic [PTR_W-1:0] ME       = PTR_W'(IDX);
	localparam logic             PAR      = 1'(IDX % 2);
	localparam bit               LEFT_OK  = (IDX + 1 < DEPTH);
	localparam bit               RIGHT_OK = (IDX > 0);

	logic             keep_q;
	logic [IDX_W-1:0] chan_q;
	logic [POS_W-1:0] pos_q;
	slot_t            slot_d;
	logic             in_range;
	logic             is_left;

	// Slot lies between head and tail of the ring
	always_comb begin
		if (head <= tail) begin
			in_range = (ME >= head) && (ME < tail);
		end else begin
			in_range = (ME >= head) || (ME < tail);
		end
	end

	assign is_left = (PAR == ctl.phase);

	// Load, mark, rotate or swap with a neighbour
	always_comb begin
		slot_d = '{keep: keep_q, chan: chan_q, pos: pos_q};
		if (push && (tail == ME)) begin
			slot_d.chan = wr_chan;
			slot_d.pos  = wr_pos;
		end else if (ctl.mark) begin
			slot_d.keep = in_range && (chan_q != rm_chan);
		end else if (ctl.rot) begin
			slot_d = right;
		end else if (ctl.sort) begin
			if (LEFT_OK && is_left && !keep_q && right.keep) begin
				slot_d = right;
			end else if (RIGHT_OK && !is_left && !left.keep && keep_q) begin
				slot_d = left;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= 1'b0;
		end else begin
			keep_q <= slot_d.keep;
		end
	end

	always_ff @(posedge clk) begin
		chan_q <= slot_d.chan;
		pos_q  <= slot_d.pos;
	end

	assign slot = '{keep: keep_q, chan: chan_q, pos: pos_q};

endmodule

[rtl/smq_seq.sv]
module smq_seq import smq_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	parameter int PTR_W = $clog2(QUEUE_DEPTH_DEF)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [PTR_W-1:0] head,
	input  logic             keep0,
	input  logic             out_free,
	output cell_ctl_t        ctl,
	output seq_stat_t        stat,
	output logic [PTR_W-1:0] live_cnt
);

	localparam int CNT_W = PTR_W + 1;

	seq_state_t       state_q;
	seq_state_t       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] live_q;
	logic [CNT_W-1:0] last_rot;

	// Full turn for counting, then head more steps to bring the head slot to cell 0
	assign last_rot = CNT_W'(DEPTH - 1) + CNT_W'(head);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (start) state_d = SQ_ROT;
			end
			SQ_ROT: begin
				if (cnt_q == last_rot) state_d = SQ_SORT;
			end
			SQ_SORT: begin
				if (cnt_q == CNT_W'(DEPTH - 1)) state_d = SQ_FIN;
			end
			SQ_FIN: begin
				if (out_free) state_d = SQ_IDLE;
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		ctl.mark  = (state_q == SQ_IDLE) && start;
		ctl.rot   = (state_q == SQ_ROT);
		ctl.sort  = (state_q == SQ_SORT);
		ctl.phase = cnt_q[0];
		stat.busy = (state_q != SQ_IDLE);
		stat.fin  = (state_q == SQ_FIN) && out_free;
	end

	// Step counter and live-slot count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			cnt_q   <= '0;
			live_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if ((state_q == SQ_ROT) || (state_q == SQ_SORT)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (ctl.mark) begin
				live_q <= '0;
			end else if ((state_q == SQ_ROT) && (cnt_q < CNT_W'(DEPTH))) begin
				live_q <= live_q + PTR_W'(keep0);
			end
		end
	end

	assign live_cnt = live_q;

endmodule

[rtl/servo_move_queue_sequencer_core.sv]
// Disarm or clear channel on a non-empty ring walks the chain of slot cells:
// rotate steps, odd-even sort rounds and a finish state that waits for a free
// result register, where its result word is registered. Every other command's
// word is registered as the command is accepted, and one word a cycle is taken
// while the result register drains and no removal pass is running.
// Reset: arst_n clears channel states, ring pointers, PWM and enable lines and
// sets the tolerance to 10; ring slot channels and positions are not cleared.
`include "servo_move_queue_sequencer_core_macros.svh"

module servo_move_queue_sequencer_core import smq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int CHANNELS    = CHANNELS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [TOL_W-1:0]         cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OP_W-1:0]          op,
	input  logic [IDX_W-1:0]         servo_index,
	input  logic [POS_W-1:0]         position,
	input  logic signed [MEAS_W-1:0] measured_position,
	input  logic                     success,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     done_res,
	output logic [STATUS_W-1:0]      status_word,
	output logic [IDX_W-1:0]         event_channel,
	output logic                     compare_valid,
	output logic [CMP_W-1:0]         compare_value,
	output logic [VEC_W-1:0]         pwm_enables,
	output logic [VEC_W-1:0]         reset_lines,
	output logic                     reset_pulse,
	output logic                     move_failed,
	output logic [SLOT_W-1:0]        failed_slot,
	output logic [COUNT_W-1:0]       queue_count
);

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int SPAN_W = PTR_W + 1;

	logic [TOL_W-1:0]    tol_q;
	ch_state_t           cs_q [CHANNELS];
	ch_state_t           cs_d [CHANNELS];
	logic [CHANNELS-1:0] pwm_q, pwm_d;
	logic [CHANNELS-1:0] en_q, en_d;
	logic [PTR_W-1:0]    head_q, head_d, tail_q, tail_d;
	logic [PTR_W-1:0]    head_inc, tail_inc;
	res_t                res_q, res_d;
	logic                out_valid_q;

	slot_t               slots [QUEUE_DEPTH];
	slot_t               head_slot;
	cell_ctl_t           cell_ctl;
	seq_stat_t           seq_stat;
	logic [PTR_W-1:0]    live_cnt;

	logic                accept, out_free, nonempty, full, idx_ok;
	logic                push, start;
	logic [CHANNELS-1:0] idx_hit, hc_hit;
	ch_state_t           st_idx;
	logic [IDX_W-1:0]    hc;
	logic [POS_W-1:0]    hp;
	logic signed [MEAS_W:0] diff;
	logic [MEAS_W-1:0]   pos_err;
	logic [SPAN_W-1:0]   span;
	logic [STATUS_W-1:0] status_v;
	logic [VEC_W-1:0]    pwm_v, en_v;

	// Handshake
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !seq_stat.busy && out_free;
	assign accept   = in_valid && in_ready;

	// Ring pointers
	assign nonempty  = (head_q != tail_q);
	assign head_inc  = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_inc  = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
	assign full      = (tail_inc == head_q);
	assign head_slot = slots[head_q];
	assign hc        = head_slot.chan;
	assign hp        = head_slot.pos;

	// Channel decode
	assign idx_ok = (32'(servo_index) < CHANNELS);
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			idx_hit[c] = idx_ok && (32'(servo_index) == c);
			hc_hit[c]  = (32'(hc) == c);
		end
	end

	always_comb begin
		st_idx = ST_DISARMED;
		for (int c = 0; c < CHANNELS; c++) begin
			if (idx_hit[c]) st_idx = cs_q[c];
		end
	end

	// Distance between head position and feedback
	assign diff = $signed({{(MEAS_W + 1 - POS_W){1'b0}}, hp})
		- $signed({measured_position[MEAS_W-1], measured_position});
	assign pos_err = diff[MEAS_W] ? MEAS_W'(-diff) : MEAS_W'(diff);

	// Command decode and next state
	always_comb begin
		cs_d   = cs_q;
		pwm_d  = pwm_q;
		en_d   = en_q;
		head_d = head_q;
		tail_d = tail_q;
		push   = 1'b0;
		start  = 1'b0;
		res_d  = '0;
		if (accept) begin
			case (op)
				OP_ARM: begin
					for (int c = 0; c < CHANNELS; c++) begin
						if (idx_hit[c]) begin
							cs_d[c] = ST_ARMED;
							en_d[c] = 1'b1;
						end
					end
				end
				OP_DISARM: begin
					for (int c = 0; c < CHANNELS; c++) begin
						if (idx_hit[c]) begin
							cs_d[c]  = ST_DISARMED;
							pwm_d[c] = 1'b0;
							en_d[c]  = 1'b0;
						end
					end
					start = idx_ok && nonempty;
				end
				OP_DISARM_ALL: begin
					for (int c = 0; c < CHANNELS; c++) begin
						cs_d[c] = ST_DISARMED;
					end
					pwm_d = '0;
					en_d  = '0;
					// every queued move belongs to some channel, so the ring empties
					if (nonempty) begin
						head_d = '0;
						tail_d = '0;
					end
				end
				OP_SET_POS: begin
					if (idx_ok && (st_idx inside {ST_ARMED, ST_MOVING}) && !full) begin
						push   = 1'b1;
						tail_d = tail_inc;
					end
				end
				OP_POLL: begin
					if (nonempty) begin
						if (hp <= POS_W'(POS_MAX)) begin
							res_d.compare_valid = 1'b1;
							res_d.compare_value = CMP_W'(hp) + CMP_W'(PULSE_OFFSET);
						end
						for (int c = 0; c < CHANNELS; c++) begin
							if (hc_hit[c]) begin
								cs_d[c]  = ST_MOVING;
								pwm_d[c] = 1'b1;
							end
						end
						res_d.done_res      = 1'b1;
						res_d.event_channel = hc;
					end
				end
				OP_CHECK: begin
					if (nonempty) begin
						res_d.done_res = (pos_err <= {{(MEAS_W - TOL_W){1'b0}}, tol_q});
					end
				end
				OP_COMPLETE: begin
					if (nonempty) begin
						for (int c = 0; c < CHANNELS; c++) begin
							if (hc_hit[c]) begin
								pwm_d[c] = 1'b0;
								cs_d[c]  = success ? ST_ARMED : ST_ERROR;
								en_d[c]  = 1'b1;
							end
						end
						if (!success) begin
							res_d.move_failed = 1'b1;
							res_d.failed_slot = SLOT_W'(head_q);
						end
						head_d              = head_inc;
						res_d.reset_pulse   = 1'b1;
						res_d.event_channel = hc;
					end
				end
				OP_CLEAR: begin
					head_d = '0;
					tail_d = '0;
				end
				OP_CLEAR_CHAN: begin
					start = idx_ok && nonempty;
				end
				default: begin
				end
			endcase
		end
		// Compacted ring restarts at slot 0
		if (seq_stat.fin) begin
			head_d = '0;
			tail_d = live_cnt;
		end
		res_d.status_word = status_v;
		res_d.pwm_enables = pwm_v;
		res_d.reset_lines = en_v;
		res_d.queue_count = (32'(span) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(span);
	end

	// Queue fill after this word
	always_comb begin
		span = {1'b0, tail_d} - {1'b0, head_d};
		if (tail_d < head_d) span = span + SPAN_W'(QUEUE_DEPTH);
	end

	// Pack the first four channels into the result
	for (genvar g = 0; g < 4; g++) begin : g_pack
		if (g < CHANNELS) begin : g_live
			assign status_v[2*g +: 2] = cs_d[g];
			assign pwm_v[g]           = pwm_d[g];
			assign en_v[g]            = en_d[g];
		end else begin : g_none
			assign status_v[2*g +: 2] = 2'b00;
			assign pwm_v[g]           = 1'b0;
			assign en_v[g]            = 1'b0;
		end
	end

	// Chain of slot cells
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		smq_cell #(
			.DEPTH(QUEUE_DEPTH),
			.PTR_W(PTR_W),
			.IDX  (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl),
			.push   (push),
			.head   (head_q),
			.tail   (tail_q),
			.rm_chan(servo_index),
			.wr_chan(servo_index),
			.wr_pos (position),
			.left   (slots[(g + QUEUE_DEPTH - 1) % QUEUE_DEPTH]),
			.right  (slots[(g + 1) % QUEUE_DEPTH]),
			.slot   (slots[g])
		);
	end

	smq_seq #(
		.DEPTH(QUEUE_DEPTH),
		.PTR_W(PTR_W)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.head    (head_q),
		.keep0   (slots[0].keep),
		.out_free(out_free),
		.ctl     (cell_ctl),
		.stat    (seq_stat),
		.live_cnt(live_cnt)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= TOL_RESET;
			for (int c = 0; c < CHANNELS; c++) begin
				cs_q[c] <= ST_DISARMED;
			end
			pwm_q       <= '0;
			en_q        <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) tol_q <= cfg_wdata;
			cs_q   <= cs_d;
			pwm_q  <= pwm_d;
			en_q   <= en_d;
			head_q <= head_d;
			tail_q <= tail_d;
			if ((accept && !start) || seq_stat.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result word register
	always_ff @(posedge clk) begin
		if ((accept && !start) || seq_stat.fin) res_q <= res_d;
	end

	assign out_valid     = out_valid_q;
	assign done_res      = res_q.done_res;
	assign status_word   = res_q.status_word;
	assign event_channel = res_q.event_channel;
	assign compare_valid = res_q.compare_valid;
	assign compare_value = res_q.compare_value;
	assign pwm_enables   = res_q.pwm_enables;
	assign reset_lines   = res_q.reset_lines;
	assign reset_pulse   = res_q.reset_pulse;
	assign move_failed   = res_q.move_failed;
	assign failed_slot   = res_q.failed_slot;
	assign queue_count   = res_q.queue_count;

	`SMQ_ASSERT_NEXT(a_push_nonempty, clk, arst_n, push, head_q != tail_q,
		"ring empty after a queued move")
	`SMQ_ASSERT_NEXT(a_fin_head_zero, clk, arst_n, seq_stat.fin, head_q == '0,
		"compacted ring does not start at slot 0")
	`SMQ_ASSERT_NEXT(a_fin_result, clk, arst_n, seq_stat.fin, out_valid_q,
		"no result after removal pass")
	`SMQ_ASSERT_NEXT(a_word_result, clk, arst_n, accept && !start, out_valid_q,
		"no result after a one-cycle command")
	`SMQ_ASSERT_SAME(a_no_push_busy, clk, arst_n, seq_stat.busy, !push && !cell_ctl.mark,
		"ring written during removal pass")

endmodule

[dv/tb_top.sv]
module tb_top import smq_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_SLOTS    = QUEUE_DEPTH_DEF;
	localparam int NUM_CHANNELS  = CHANNELS_DEF;
	localparam int SETTLE_CYCLES = 3 * RING_SLOTS + 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int BATCH_ITEMS   = 275;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [IDX_W-1:0]         idx;
		logic [POS_W-1:0]         pos;
		logic signed [MEAS_W-1:0] meas;
		logic                     succ;
	} servo_cmd_t;

	logic                     clk;
	logic                     arst_n            = 1'b0;
	logic                     cfg_we            = 1'b0;
	logic [TOL_W-1:0]         cfg_wdata         = '0;
	logic                     in_valid          = 1'b0;
	logic                     in_ready;
	logic [OP_W-1:0]          cmd_op            = '0;
	logic [IDX_W-1:0]         cmd_index         = '0;
	logic [POS_W-1:0]         cmd_position      = '0;
	logic signed [MEAS_W-1:0] cmd_measured      = '0;
	logic                     cmd_success       = 1'b0;
	logic                     out_valid;
	logic                     out_ready         = 1'b0;
	logic                     done_res;
	logic [STATUS_W-1:0]      status_word;
	logic [IDX_W-1:0]         event_channel;
	logic                     compare_valid;
	logic [CMP_W-1:0]         compare_value;
	logic [VEC_W-1:0]         pwm_enables;
	logic [VEC_W-1:0]         reset_lines;
	logic                     reset_pulse;
	logic                     move_failed;
	logic [SLOT_W-1:0]        failed_slot;
	logic [COUNT_W-1:0]       queue_count;

	// Pending commands, the command on the port, and predicted result words
	servo_cmd_t pending_cmds[$];
	servo_cmd_t on_port;
	res_t       expected_words[$];

	int send_idle_pct = 18;
	int recv_idle_pct = 75;
	int cmds_queued   = 0;
	int words_seen    = 0;
	int mismatches    = 0;
	int hold_left     = 0;
	int cycle_count   = 0;
	logic hold_start  = 1'b0;

	// Predictor state
	ch_state_t        chan_mode[NUM_CHANNELS];
	logic [IDX_W-1:0] slot_chan[RING_SLOTS];
	logic [POS_W-1:0] slot_pos[RING_SLOTS];
	logic [SLOT_W-1:0] rd_ptr;
	logic [SLOT_W-1:0] wr_ptr;
	logic [VEC_W-1:0] pwm_on;
	logic [VEC_W-1:0] en_lines;
	logic [TOL_W-1:0] tol_now;

	servo_move_queue_sequencer_core DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.op                (cmd_op),
		.servo_index       (cmd_index),
		.position          (cmd_position),
		.measured_position (cmd_measured),
		.success           (cmd_success),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.done_res          (done_res),
		.status_word       (status_word),
		.event_channel     (event_channel),
		.compare_valid     (compare_valid),
		.compare_value     (compare_value),
		.pwm_enables       (pwm_enables),
		.reset_lines       (reset_lines),
		.reset_pulse       (reset_pulse),
		.move_failed       (move_failed),
		.failed_slot       (failed_slot),
		.queue_count       (queue_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Drop one channel's moves, pack the survivors from slot 0
	function automatic void purge_channel(input logic [IDX_W-1:0] ch);
		logic [IDX_W-1:0]  kept_chan[RING_SLOTS];
		logic [POS_W-1:0]  kept_pos[RING_SLOTS];
		logic [SLOT_W-1:0] n;
		logic [SLOT_W-1:0] s;
		int k;
		if (rd_ptr == wr_ptr)
			return;
		for (k = 0; k < RING_SLOTS; k++) begin
			kept_chan[k] = '0;
			kept_pos[k] = '0;
		end
		n = '0;
		s = rd_ptr;
		while (s != wr_ptr) begin
			if (slot_chan[s] != ch) begin
				kept_chan[n] = slot_chan[s];
				kept_pos[n] = slot_pos[s];
				n = n + SLOT_W'(1);
			end
			s = s + SLOT_W'(1);
		end
		slot_chan = kept_chan;
		slot_pos = kept_pos;
		rd_ptr = '0;
		wr_ptr = n;
	endfunction

	function automatic void disarm_channel(input logic [IDX_W-1:0] ch);
		chan_mode[ch] = ST_DISARMED;
		pwm_on[ch] = 1'b0;
		en_lines[ch] = 1'b0;
		purge_channel(ch);
	endfunction

	// Work out the result word of one command and advance the predictor
	function automatic res_t predict_servo_step(input servo_cmd_t c);
		res_t              r;
		logic [IDX_W-1:0]  hc;
		logic [POS_W-1:0]  hp;
		logic [SLOT_W-1:0] next_wr;
		logic              ring_busy;
		int                gap;
		int                ch;
		r = '0;
		hc = slot_chan[rd_ptr];
		hp = slot_pos[rd_ptr];
		ring_busy = (rd_ptr != wr_ptr);
		next_wr = wr_ptr + SLOT_W'(1);
		case (c.op)
			OP_ARM: begin
				chan_mode[c.idx] = ST_ARMED;
				en_lines[c.idx] = 1'b1;
			end
			OP_DISARM: disarm_channel(c.idx);
			OP_DISARM_ALL: begin
				for (ch = 0; ch < NUM_CHANNELS; ch++)
					disarm_channel(IDX_W'(ch));
			end
			OP_SET_POS: begin
				if ((chan_mode[c.idx] == ST_ARMED || chan_mode[c.idx] == ST_MOVING)
						&& next_wr != rd_ptr) begin
					slot_chan[wr_ptr] = c.idx;
					slot_pos[wr_ptr] = c.pos;
					wr_ptr = next_wr;
				end
			end
			OP_POLL: begin
				if (ring_busy) begin
					if (int'(hp) <= POS_MAX) begin
						r.compare_valid = 1'b1;
						r.compare_value = CMP_W'(int'(hp) + PULSE_OFFSET);
					end
					chan_mode[hc] = ST_MOVING;
					pwm_on[hc] = 1'b1;
					r.done_res = 1'b1;
					r.event_channel = hc;
				end
			end
			OP_CHECK: begin
				if (ring_busy) begin
					gap = int'(hp) - int'($signed(c.meas));
					if (gap < 0)
						gap = -gap;
					if (gap <= int'(tol_now))
						r.done_res = 1'b1;
				end
			end
			OP_COMPLETE: begin
				if (ring_busy) begin
					pwm_on[hc] = 1'b0;
					if (c.succ) begin
						chan_mode[hc] = ST_ARMED;
					end else begin
						chan_mode[hc] = ST_ERROR;
						r.move_failed = 1'b1;
						r.failed_slot = rd_ptr;
					end
					rd_ptr = rd_ptr + SLOT_W'(1);
					en_lines[hc] = 1'b1;
					r.reset_pulse = 1'b1;
					r.event_channel = hc;
				end
			end
			OP_CLEAR: begin
				rd_ptr = '0;
				wr_ptr = '0;
			end
			OP_CLEAR_CHAN: purge_channel(c.idx);
			default: ;
		endcase
		for (ch = 0; ch < NUM_CHANNELS; ch++)
			r.status_word[2*ch +: 2] = chan_mode[ch];
		r.pwm_enables = pwm_on;
		r.reset_lines = en_lines;
		r.queue_count = wr_ptr - rd_ptr;
		return r;
	endfunction

	// Driver: hold the word until taken, then offer the next one or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_words.push_back(predict_servo_step(on_port));
			if (!in_valid || in_ready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_port = pending_cmds.pop_front();
					cmd_op <= on_port.op;
					cmd_index <= on_port.idx;
					cmd_position <= on_port.pos;
					cmd_measured <= on_port.meas;
					cmd_success <= on_port.succ;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Monitor: compare each word taken, then pick the next ready level
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				words_seen++;
				if (expected_words.size() == 0) begin
					$error("result word with no command outstanding");
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					check_field("done_res", 32'(want.done_res), 32'(done_res));
					check_field("status_word", 32'(want.status_word), 32'(status_word));
					check_field("event_channel", 32'(want.event_channel),
						32'(event_channel));
					check_field("compare_valid", 32'(want.compare_valid),
						32'(compare_valid));
					check_field("compare_value", 32'(want.compare_value),
						32'(compare_value));
					check_field("pwm_enables", 32'(want.pwm_enables), 32'(pwm_enables));
					check_field("reset_lines", 32'(want.reset_lines), 32'(reset_lines));
					check_field("reset_pulse", 32'(want.reset_pulse), 32'(reset_pulse));
					check_field("move_failed", 32'(want.move_failed), 32'(move_failed));
					check_field("failed_slot", 32'(want.failed_slot), 32'(failed_slot));
					check_field("queue_count", 32'(want.queue_count), 32'(queue_count));
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (hold_start) begin
				hold_left <= HOLD_CYCLES;
				hold_start <= 1'b0;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL servo_move_queue_sequencer_core");
			$finish;
		end
	end

	task automatic queue_cmd(input int o, input int idx, input int pos, input int meas,
			input int succ);
		servo_cmd_t c;
		c.op = o[OP_W-1:0];
		c.idx = idx[IDX_W-1:0];
		c.pos = pos[POS_W-1:0];
		c.meas = meas[MEAS_W-1:0];
		c.succ = succ[0];
		pending_cmds.push_back(c);
		cmds_queued++;
	endtask

	task automatic wait_drained();
		while (words_seen < cmds_queued)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [TOL_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tol_now = v;
	endtask

	// Feedback near the target most of the time, raw noise otherwise
	function automatic int feedback_for(input int pos);
		int span;
		span = int'(tol_now) + 2;
		if ($urandom_range(3) == 0)
			return int'($urandom_range(4095));
		return pos + int'($urandom_range(2 * span)) - span;
	endfunction

	task automatic run_directed();
		// empty ring: poll, check and complete do nothing
		queue_cmd(OP_POLL, 0, 0, 0, 1);
		queue_cmd(OP_CHECK, 0, 0, 0, 1);
		queue_cmd(OP_COMPLETE, 0, 0, 0, 0);
		// set position on a disarmed channel is dropped
		queue_cmd(OP_SET_POS, 0, 500, 0, 0);
		for (int ch = 0; ch < NUM_CHANNELS; ch++)
			queue_cmd(OP_ARM, ch, 0, 0, 0);
		queue_cmd(OP_SET_POS, 0, 0, 0, 0);
		queue_cmd(OP_SET_POS, 1, 1023, 2047, 1);
		queue_cmd(OP_SET_POS, 2, 1000, -2048, 0);
		queue_cmd(OP_SET_POS, 3, 500, 0, 1);
		queue_cmd(OP_POLL, 0, 0, 0, 0);
		queue_cmd(OP_CHECK, 0, 0, 10, 0);
		queue_cmd(OP_CHECK, 0, 0, -2048, 0);
		queue_cmd(OP_COMPLETE, 0, 0, 0, 1);
		// head above full travel: no compare write
		queue_cmd(OP_POLL, 0, 0, 0, 0);
		queue_cmd(OP_CHECK, 0, 0, 2047, 0);
		queue_cmd(OP_COMPLETE, 0, 0, 0, 0);
		// error channel refuses moves
		queue_cmd(OP_SET_POS, 1, 300, 0, 0);
		queue_cmd(15, 3, 1023, -1, 1);
		queue_cmd(OP_CLEAR_CHAN, 2, 0, 0, 0);
		queue_cmd(OP_DISARM, 3, 0, 0, 0);
		queue_cmd(OP_DISARM_ALL, 0, 0, 0, 0);
		queue_cmd(OP_CLEAR, 0, 0, 0, 0);
	endtask

	// Mostly whole move sequences (arm, queue, poll, check, complete), some noise
	task automatic run_traffic(input int n_items);
		int made;
		int n_moves;
		int pos;
		int targets[$];
		made = 0;
		while (made < n_items) begin
			if ($urandom_range(99) < 20) begin
				queue_cmd($urandom_range(15), $urandom_range(3), $urandom_range(1023),
					$urandom_range(4095), $urandom_range(1));
				made++;
			end else begin
				targets.delete();
				if ($urandom_range(99) < 70) begin
					queue_cmd(OP_CLEAR, $urandom_range(3), $urandom_range(1023),
						$urandom_range(4095), $urandom_range(1));
					made++;
				end
				for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
					if ($urandom_range(9) != 0) begin
						queue_cmd(OP_ARM, ch, $urandom_range(1023), $urandom_range(4095),
							$urandom_range(1));
						made++;
					end
				end
				n_moves = ($urandom_range(7) == 0) ? $urandom_range(14, 18)
					: $urandom_range(1, 6);
				for (int j = 0; j < n_moves; j++) begin
					pos = ($urandom_range(9) == 0) ? $urandom_range(1001, 1023)
						: $urandom_range(1000);
					queue_cmd(OP_SET_POS, $urandom_range(3), pos, $urandom_range(4095),
						$urandom_range(1));
					if (targets.size() < RING_SLOTS - 1)
						targets.push_back(pos);
					made++;
				end
				// occasionally upset the queue mid-sequence
				if ($urandom_range(9) == 0) begin
					queue_cmd($urandom_range(1) ? OP_DISARM : OP_CLEAR_CHAN,
						$urandom_range(3), $urandom_range(1023), $urandom_range(4095),
						$urandom_range(1));
					made++;
				end
				foreach (targets[t]) begin
					queue_cmd(OP_POLL, $urandom_range(3), $urandom_range(1023),
						$urandom_range(4095), $urandom_range(1));
					queue_cmd(OP_CHECK, $urandom_range(3), $urandom_range(1023),
						feedback_for(targets[t]), $urandom_range(1));
					queue_cmd(OP_COMPLETE, $urandom_range(3), $urandom_range(1023),
						$urandom_range(4095), $urandom_range(9) != 0);
					made += 3;
				end
			end
		end
	endtask

	initial begin
		for (int ch = 0; ch < NUM_CHANNELS; ch++)
			chan_mode[ch] = ST_DISARMED;
		for (int s = 0; s < RING_SLOTS; s++) begin
			slot_chan[s] = '0;
			slot_pos[s] = '0;
		end
		rd_ptr = '0;
		wr_ptr = '0;
		pwm_on = '0;
		en_lines = '0;
		tol_now = TOL_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles rarely, receiver often
		run_directed();
		wait_drained();
		write_tolerance('0);
		hold_start <= 1'b1;
		run_traffic(BATCH_ITEMS);
		wait_drained();
		run_traffic(BATCH_ITEMS);
		wait_drained();

		// swap the idling sides
		send_idle_pct = 75;
		recv_idle_pct = 18;
		write_tolerance({TOL_W{1'b1}});
		run_traffic(BATCH_ITEMS);
		wait_drained();
		run_traffic(BATCH_ITEMS);
		wait_drained();

		// full rate on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_tolerance(TOL_W'($urandom_range(1, 1022)));
		run_traffic(BATCH_ITEMS);
		wait_drained();
		run_traffic(BATCH_ITEMS);
		wait_drained();

		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("PASS servo_move_queue_sequencer_core");
		end else begin
			$display("FAIL servo_move_queue_sequencer_core");
		end
		$finish;
	end

endmodule
